/* hw/rtl/smmt_pkg.sv */
// ----------------------------------------------------------------------------
// Square matrix multiply with trace: shared package
// Field widths, microcode word layout, the control program and the
// control and status bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package smmt_pkg;

    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 35;
    localparam int TRACE_W    = 38;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;
    localparam int STEP_W     = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        W_NONE     = 2'd0,
        W_NO_GO    = 2'd1,
        W_K_MORE   = 2'd2,
        W_OUT_BUSY = 2'd3
    } t_wait_sel;

    typedef enum logic {
        B_NONE      = 1'b0,
        B_ELEM_LAST = 1'b1
    } t_br_sel;

    typedef struct packed {
        logic              in_ready;
        logic              init;
        logic              issue;
        logic              emit;
        t_wait_sel         wait_sel;
        t_br_sel           br_sel;
        logic [STEP_W-1:0] target;
        logic [STEP_W-1:0] next_step;
    } t_uword;

    typedef struct packed {
        logic in_ready;
        logic init;
        logic issue;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic go_load;
        logic k_last;
        logic out_busy;
        logic elem_last;
    } t_stat;

    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_INIT  = 3'd1;
    localparam logic [STEP_W-1:0] ST_ISSUE = 3'd2;
    localparam logic [STEP_W-1:0] ST_DRAIN = 3'd3;
    localparam logic [STEP_W-1:0] ST_EMIT  = 3'd4;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{in_ready: 1'b1, init: 1'b0, issue: 1'b0, emit: 1'b0,
              wait_sel: W_NO_GO, br_sel: B_NONE, target: ST_IDLE, next_step: ST_INIT};
        unique case (step)
            ST_IDLE: begin
                w = '{in_ready: 1'b1, init: 1'b0, issue: 1'b0, emit: 1'b0,
                      wait_sel: W_NO_GO, br_sel: B_NONE, target: ST_IDLE,
                      next_step: ST_INIT};
            end
            ST_INIT: begin
                w = '{in_ready: 1'b0, init: 1'b1, issue: 1'b0, emit: 1'b0,
                      wait_sel: W_NONE, br_sel: B_NONE, target: ST_IDLE,
                      next_step: ST_ISSUE};
            end
            ST_ISSUE: begin
                w = '{in_ready: 1'b0, init: 1'b0, issue: 1'b1, emit: 1'b0,
                      wait_sel: W_K_MORE, br_sel: B_NONE, target: ST_IDLE,
                      next_step: ST_DRAIN};
            end
            ST_DRAIN: begin
                w = '{in_ready: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b0,
                      wait_sel: W_NONE, br_sel: B_NONE, target: ST_IDLE,
                      next_step: ST_EMIT};
            end
            ST_EMIT: begin
                w = '{in_ready: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b1,
                      wait_sel: W_OUT_BUSY, br_sel: B_ELEM_LAST, target: ST_IDLE,
                      next_step: ST_ISSUE};
            end
            default: begin
                w = '{in_ready: 1'b0, init: 1'b0, issue: 1'b0, emit: 1'b0,
                      wait_sel: W_NONE, br_sel: B_NONE, target: ST_IDLE,
                      next_step: ST_IDLE};
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/smmt_seq.sv */
// ----------------------------------------------------------------------------
// Square matrix multiply with trace: microcode sequencer
// Step counter over a small control program; each step waits on at most one status
// condition and then branches or falls through to its next step.
// ----------------------------------------------------------------------------
module smmt_seq
    import smmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              hold;
    logic              take_br;

    assign uw = ucode(r_step);

    always_comb begin
        unique case (uw.wait_sel)
            W_NONE:     hold = 1'b0;
            W_NO_GO:    hold = !i_stat.go_load;
            W_K_MORE:   hold = !i_stat.k_last;
            W_OUT_BUSY: hold = i_stat.out_busy;
            default:    hold = 1'b0;
        endcase
    end

    assign take_br = (uw.br_sel == B_ELEM_LAST) && i_stat.elem_last;

    always_comb begin
        priority if (hold) begin
            n_step = r_step;
        end else if (take_br) begin
            n_step = uw.target;
        end else begin
            n_step = uw.next_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = '{in_ready: uw.in_ready, init: uw.init,
                      issue: uw.issue, emit: uw.emit};

endmodule

/* hw/rtl/smmt_dp.sv */
// ----------------------------------------------------------------------------
// Square matrix multiply with trace: datapath
// Element stores, index counters, one pipelined multiply-accumulate unit,
// the trace accumulator and the result register.
// ----------------------------------------------------------------------------
module smmt_dp
    import smmt_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    input  t_ctrl                 i_ctrl,
    output t_stat                 o_stat
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
    localparam logic [VAL_W-1:0] ELEM_MASK =
        (FRAC_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << FRAC_BITS) - 64'd1);

    logic [VAL_W-1:0]      mem_a [DEPTH];
    logic [VAL_W-1:0]      mem_b [DEPTH];

    logic [DIM_W-1:0]      r_dim;
    logic [DIM_W-1:0]      size_n;
    logic [IDX_W-1:0]      in_row;
    logic [IDX_W-1:0]      in_col;
    logic [VAL_W-1:0]      in_val;
    logic                  wr_en;
    logic [6:0]            wr_full;
    logic [6:0]            rda_full;
    logic [6:0]            rdb_full;

    logic [IDX_W-1:0]      r_k;
    logic [IDX_W-1:0]      r_row;
    logic [IDX_W-1:0]      r_col;
    logic [VAL_W-1:0]      r_rd_a;
    logic [VAL_W-1:0]      r_rd_b;
    logic                  r_v1;
    logic                  r_v2;
    logic [2*VAL_W-1:0]    r_prod;
    logic [PROD_W-1:0]     r_acc;
    logic [PROD_W-1:0]     sum;
    logic [TRACE_W-1:0]    r_trace;
    logic [TRACE_W-1:0]    trace_now;

    logic                  k_last;
    logic                  row_last;
    logic                  col_last;
    logic                  diag;
    logic                  out_busy;
    logic                  fire;

    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_o_row;
    logic [IDX_W-1:0]      r_o_col;
    logic [PROD_W-1:0]     r_o_prod;
    logic [TRACE_W-1:0]    r_o_trace;
    logic                  r_o_last;

    assign in_row = i_s_tdata[2:0];
    assign in_col = i_s_tdata[5:3];
    assign in_val = i_s_tdata[21:6] & ELEM_MASK;

    always_comb begin
        priority if (r_dim == '0) begin
            size_n = 4'd1;
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            size_n = DIM_W'(MAX_DIM);
        end else begin
            size_n = r_dim;
        end
    end

    assign wr_en = i_s_tvalid && i_ctrl.in_ready
                   && (DIM_W'(in_row) < DIM_W'(MAX_DIM))
                   && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
    assign wr_full  = 7'(in_row) * 7'(MAX_DIM) + 7'(in_col);
    assign rda_full = 7'(r_row) * 7'(MAX_DIM) + 7'(r_k);
    assign rdb_full = 7'(r_k) * 7'(MAX_DIM) + 7'(r_col);

    always_ff @(posedge i_clk) begin
        if (wr_en && !i_s_tuser) begin
            mem_a[wr_full[AW-1:0]] <= in_val;
        end
        if (wr_en && i_s_tuser) begin
            mem_b[wr_full[AW-1:0]] <= in_val;
        end
        if (i_ctrl.issue) begin
            r_rd_a <= mem_a[rda_full[AW-1:0]];
            r_rd_b <= mem_b[rdb_full[AW-1:0]];
        end
        if (r_v1) begin
            r_prod <= r_rd_a * r_rd_b;
        end
    end

    assign k_last   = (DIM_W'(r_k) == size_n - 4'd1);
    assign row_last = (DIM_W'(r_row) == size_n - 4'd1);
    assign col_last = (DIM_W'(r_col) == size_n - 4'd1);
    assign diag     = (r_row == r_col);
    assign out_busy = r_out_valid && !i_m_tready;
    assign fire     = i_ctrl.emit && !out_busy;

    assign sum       = r_acc + PROD_W'(r_prod);
    assign trace_now = r_trace + (diag ? TRACE_W'(sum) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= DIM_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_k         <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_acc       <= '0;
            r_trace     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dim <= i_cfg_data;
            end
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;

            if (i_ctrl.init || fire) begin
                r_k <= '0;
            end else if (i_ctrl.issue) begin
                r_k <= r_k + 3'd1;
            end

            if (i_ctrl.init || fire) begin
                r_acc <= '0;
            end else if (r_v2 && !i_ctrl.emit) begin
                r_acc <= r_acc + PROD_W'(r_prod);
            end

            if (i_ctrl.init) begin
                r_row   <= '0;
                r_col   <= '0;
                r_trace <= '0;
            end else if (fire) begin
                r_trace <= trace_now;
                if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + 3'd1;
                end else begin
                    r_col <= r_col + 3'd1;
                end
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_prod  <= sum;
            r_o_trace <= (row_last && col_last) ? trace_now : '0;
            r_o_last  <= row_last && col_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_o_trace, r_o_prod, r_o_col, r_o_row};
    assign o_m_tlast  = r_o_last;

    assign o_stat = '{go_load: i_s_tvalid && i_ctrl.in_ready && i_s_tlast,
                      k_last: k_last,
                      out_busy: out_busy,
                      elem_last: row_last && col_last};

endmodule

/* hw/rtl/square_matrix_multiply_trace.sv */
// Sequence: load items are taken only while idle; after the item marked last is
// taken, the sequencer steps through init, issue, drain and emit, and the first
// product element is registered when emit fires. Elements are computed one at a
// time by the single shared multiply-accumulate unit, one read port per element store.
// Reset: synchronous, active low; clears the sequencer, counters, trace and the
// result valid and sets the size to 8. The element stores are not cleared.
// ----------------------------------------------------------------------------
// Square matrix multiply with trace: top level
// Loads matrices A and B, then streams C = A * B in row-major order with the
// trace of C on the final item.
// ----------------------------------------------------------------------------
module square_matrix_multiply_trace
    import smmt_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DIM_W-1:0]      i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
    input  logic                  i_s_tuser,   // kind[0]
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // out_row[2:0], out_col[5:3],
                                               // product_value[40:6],
                                               // trace_value[78:41], zero pad
    output logic                  o_m_tlast
);

    t_ctrl ctrl;
    t_stat stat;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ctrl.in_ready;

    smmt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    smmt_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_ctrl      (ctrl),
        .o_stat      (stat)
    );

endmodule

/* hw/rtl/smmt_chk.sv */
// ----------------------------------------------------------------------------
// Square matrix multiply with trace: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module smmt_chk
    import smmt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result item changed while stalled");

    a_go_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input still ready after the final load item");

    a_trace_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[78:41] == 38'd0)
        else $error("trace nonzero on a result item that is not last");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[2:0] == o_m_tdata[5:3])
        else $error("final result item is not on the diagonal");

endmodule

bind square_matrix_multiply_trace smmt_chk u_smmt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
